@@ hw/rtl/smx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants for the stack machine execute unit.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int CW          = $clog2(STACK_DEPTH + 1);

  localparam logic [4:0] CMD_NOP     = 5'd0;
  localparam logic [4:0] CMD_PUSHIMM = 5'd1;
  localparam logic [4:0] CMD_PUSHIN  = 5'd2;
  localparam logic [4:0] CMD_POP     = 5'd3;
  localparam logic [4:0] CMD_ADD     = 5'd4;
  localparam logic [4:0] CMD_SUB     = 5'd5;
  localparam logic [4:0] CMD_MUL     = 5'd6;
  localparam logic [4:0] CMD_DIV     = 5'd7;
  localparam logic [4:0] CMD_MOD     = 5'd8;
  localparam logic [4:0] CMD_GT      = 5'd9;
  localparam logic [4:0] CMD_NOT     = 5'd10;
  localparam logic [4:0] CMD_DUP     = 5'd11;
  localparam logic [4:0] CMD_SWAP    = 5'd12;
  localparam logic [4:0] CMD_ROLL    = 5'd13;
  localparam logic [4:0] CMD_OUTNUM  = 5'd14;
  localparam logic [4:0] CMD_OUTCHAR = 5'd15;
  localparam logic [4:0] CMD_POINTER = 5'd16;
  localparam logic [4:0] CMD_SWITCH  = 5'd17;
  localparam logic [4:0] CMD_JEZ     = 5'd18;

  typedef struct packed {
    logic [4:0]         cmd;
    logic signed [31:0] immediate;
    logic signed [31:0] in_value;
  } instr_t;

  typedef struct packed {
    logic [1:0]         branch;
    logic               out_valid;
    logic               out_kind;
    logic signed [31:0] out_value;
    logic               ignored;
    logic               overflow;
    logic [8:0]         stack_count;
  } result_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic cap_b;
    logic rd_second;
    logic cap_a;
    logic div_start;
    logic roll_setup;
    logic roll_copy;
    logic roll_write;
    logic swap2;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic quick;
    logic need2;
    logic is_swap;
    logic is_roll;
    logic long_op;
    logic div_done;
    logic copy_last;
    logic write_last;
  } dp_status_t;

endpackage

@@ hw/rtl/smx_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_div
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module smx_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic signed [31:0] quotient,
  output logic signed [31:0] remainder,
  output logic               done
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        run;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] trial;

  assign trial = {rem, quo[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= dividend[31] ? 32'(-dividend) : 32'(dividend);
      dvs   <= divisor[31] ? 32'(-divisor) : 32'(divisor);
      rem   <= '0;
      neg_q <= dividend[31] ^ divisor[31];
      neg_r <= dividend[31];
    end else if (run) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient  = neg_q ? -$signed(quo) : $signed(quo);
  assign remainder = neg_r ? -$signed(rem) : $signed(rem);

endmodule

@@ hw/rtl/smx_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_datapath
// Stack memory, operand registers, ALU, divider, roll buffer and result.
// ----------------------------------------------------------------------------
module smx_datapath (
  input  logic                clk,
  input  logic                rst,
  input  smx_pkg::instr_t     instr,
  input  smx_pkg::ctrl_cmd_t  ctl,
  output smx_pkg::dp_status_t sts,
  output smx_pkg::result_t    result,
  output logic                done
);

  localparam int AW = smx_pkg::AW;
  localparam int CW = smx_pkg::CW;

  logic [31:0] stack_mem [smx_pkg::STACK_DEPTH];
  logic [31:0] roll_mem  [smx_pkg::STACK_DEPTH];

  smx_pkg::instr_t  ins;
  smx_pkg::result_t res_n;
  logic [CW-1:0] sp, sp_n, nm1, nm2, np1;
  logic signed [31:0] a, b, alu, ewd;
  logic [31:0] rd_data, buf_rd, wd, s_w;
  logic [AW-1:0] ra, ewa, wa, cp_idx, wr_addr;
  logic ew, we, cp_valid, wr_pend, full, empty, lt2, is_divmod, roll_ok;
  logic [CW-1:0] base, rlen, ri, wj, ridx, s, ridx_inc;
  logic signed [31:0] dv_a, dv_b, quo, rem;
  logic dv_done;

  assign nm1   = sp - CW'(1);
  assign nm2   = sp - CW'(2);
  assign np1   = sp + CW'(1);
  assign full  = (sp == CW'(smx_pkg::STACK_DEPTH));
  assign empty = (sp == '0);
  assign lt2   = (sp < CW'(2));
  assign is_divmod = (ins.cmd == smx_pkg::CMD_DIV) || (ins.cmd == smx_pkg::CMD_MOD);
  assign roll_ok = !a[31] && (a <= $signed({{(32-CW){1'b0}}, nm2}));

  assign dv_a = (ins.cmd == smx_pkg::CMD_ROLL) ? b : a;
  assign dv_b = (ins.cmd == smx_pkg::CMD_ROLL) ? a : b;

  smx_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (dv_a),
    .divisor   (dv_b),
    .quotient  (quo),
    .remainder (rem),
    .done      (dv_done)
  );

  always_comb begin
    sts.need2 = ins.cmd inside {[smx_pkg::CMD_ADD:smx_pkg::CMD_GT],
                                smx_pkg::CMD_SWAP, smx_pkg::CMD_ROLL};
    sts.quick = (ins.cmd inside {[smx_pkg::CMD_NOP:smx_pkg::CMD_POP]})
                || (ins.cmd > smx_pkg::CMD_JEZ) || empty || (sts.need2 && lt2);
    sts.is_swap    = (ins.cmd == smx_pkg::CMD_SWAP);
    sts.is_roll    = (ins.cmd == smx_pkg::CMD_ROLL);
    sts.long_op    = (is_divmod && (b != 0)) || (sts.is_roll && roll_ok && (a != 0));
    sts.div_done   = dv_done;
    sts.copy_last  = (ri == rlen - CW'(1));
    sts.write_last = (wj == rlen - CW'(1));
  end

  always_comb begin
    case (ins.cmd)
      smx_pkg::CMD_ADD: alu = a + b;
      smx_pkg::CMD_SUB: alu = a - b;
      smx_pkg::CMD_MUL: alu = a * b;
      smx_pkg::CMD_DIV: alu = quo;
      smx_pkg::CMD_MOD: alu = rem;
      smx_pkg::CMD_GT:  alu = (a > b) ? 32'sd1 : 32'sd0;
      default:          alu = '0;
    endcase
  end

  always_comb begin
    res_n = '0;
    ew    = 1'b0;
    ewa   = sp[AW-1:0];
    ewd   = b;
    sp_n  = sp;
    case (ins.cmd)
      smx_pkg::CMD_NOP: begin
      end
      smx_pkg::CMD_PUSHIMM, smx_pkg::CMD_PUSHIN: begin
        if (full) begin
          res_n.overflow = 1'b1;
        end else begin
          ew   = 1'b1;
          ewd  = (ins.cmd == smx_pkg::CMD_PUSHIMM) ? ins.immediate : ins.in_value;
          sp_n = np1;
        end
      end
      smx_pkg::CMD_POP: begin
        if (empty) res_n.ignored = 1'b1;
        else sp_n = nm1;
      end
      smx_pkg::CMD_ADD, smx_pkg::CMD_SUB, smx_pkg::CMD_MUL,
      smx_pkg::CMD_DIV, smx_pkg::CMD_MOD, smx_pkg::CMD_GT: begin
        if (lt2 || (is_divmod && (b == 0))) begin
          res_n.ignored = 1'b1;
        end else begin
          ew   = 1'b1;
          ewa  = nm2[AW-1:0];
          ewd  = alu;
          sp_n = nm1;
        end
      end
      smx_pkg::CMD_NOT: begin
        if (empty) begin
          res_n.ignored = 1'b1;
        end else begin
          ew  = 1'b1;
          ewa = nm1[AW-1:0];
          ewd = (b == 0) ? 32'sd1 : 32'sd0;
        end
      end
      smx_pkg::CMD_DUP: begin
        if (empty) res_n.ignored = 1'b1;
        else if (full) res_n.overflow = 1'b1;
        else begin
          ew   = 1'b1;
          sp_n = np1;
        end
      end
      smx_pkg::CMD_SWAP: begin
        if (lt2) begin
          res_n.ignored = 1'b1;
        end else begin
          ew  = 1'b1;
          ewa = nm1[AW-1:0];
          ewd = a;
        end
      end
      smx_pkg::CMD_ROLL: begin
        if (lt2 || !roll_ok) res_n.ignored = 1'b1;
        else sp_n = nm2;
      end
      smx_pkg::CMD_OUTNUM, smx_pkg::CMD_OUTCHAR: begin
        if (empty) begin
          res_n.ignored = 1'b1;
        end else begin
          res_n.out_valid = 1'b1;
          res_n.out_kind  = (ins.cmd == smx_pkg::CMD_OUTCHAR);
          res_n.out_value = b;
          sp_n            = nm1;
        end
      end
      smx_pkg::CMD_POINTER, smx_pkg::CMD_SWITCH, smx_pkg::CMD_JEZ: begin
        if (empty) begin
          res_n.ignored = 1'b1;
        end else begin
          sp_n = nm1;
          if (ins.cmd == smx_pkg::CMD_POINTER) res_n.branch = b[1:0];
          else if (ins.cmd == smx_pkg::CMD_SWITCH) res_n.branch = {1'b0, b[0]};
          else res_n.branch = {1'b0, (b == 0)};
        end
      end
      default: res_n.ignored = 1'b1;
    endcase
    res_n.stack_count = 9'(sp_n);
  end

  // read port select
  always_comb begin
    if (ctl.rd_second) ra = nm2[AW-1:0];
    else if (ctl.roll_copy) ra = base[AW-1:0] + ri[AW-1:0];
    else ra = nm1[AW-1:0];
  end

  // write port select
  always_comb begin
    we = 1'b0;
    wa = ewa;
    wd = ewd;
    if (wr_pend) begin
      we = 1'b1;
      wa = wr_addr;
      wd = buf_rd;
    end else if (ctl.swap2) begin
      we = 1'b1;
      wa = nm2[AW-1:0];
      wd = b;
    end else if (ctl.exec) begin
      we = ew;
    end
  end

  always_ff @(posedge clk) begin
    if (we) stack_mem[wa] <= wd;
    rd_data <= stack_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cp_valid) roll_mem[cp_idx] <= rd_data;
    buf_rd <= roll_mem[ridx[AW-1:0]];
  end

  assign s_w      = rem + (rem[31] ? a : 32'sd0);
  assign s        = s_w[CW-1:0];
  assign ridx_inc = ridx + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sp       <= '0;
      done     <= 1'b0;
      cp_valid <= 1'b0;
      wr_pend  <= 1'b0;
    end else begin
      done     <= ctl.finish;
      cp_valid <= ctl.roll_copy;
      wr_pend  <= ctl.roll_write;
      if (ctl.exec) sp <= sp_n;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) ins <= instr;
    if (ctl.cap_b) b <= rd_data;
    if (ctl.cap_a) a <= rd_data;
    if (ctl.exec) result <= res_n;
    if (ctl.roll_setup) begin
      rlen <= a[CW-1:0];
      base <= nm2 - a[CW-1:0];
      ri   <= '0;
      wj   <= '0;
      ridx <= (s == '0) ? '0 : a[CW-1:0] - s;
    end
    if (ctl.roll_copy) begin
      cp_idx <= ri[AW-1:0];
      ri     <= ri + CW'(1);
    end
    if (ctl.roll_write) begin
      wr_addr <= base[AW-1:0] + wj[AW-1:0];
      wj      <= wj + CW'(1);
      ridx    <= (ridx_inc == rlen) ? '0 : ridx_inc;
    end
  end

endmodule

@@ hw/rtl/smx_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer: operand fetch, execute, divide wait, swap and roll phases.
// ----------------------------------------------------------------------------
module smx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  smx_pkg::dp_status_t sts,
  output smx_pkg::ctrl_cmd_t  ctl,
  output logic                busy
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RD_B   = 4'd2;
  localparam logic [3:0] S_RD_A   = 4'd3;
  localparam logic [3:0] S_EXEC   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_SWAP2  = 4'd6;
  localparam logic [3:0] S_RCOPY  = 4'd7;
  localparam logic [3:0] S_RGAP   = 4'd8;
  localparam logic [3:0] S_RWRITE = 4'd9;
  localparam logic [3:0] S_RLAST  = 4'd10;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.quick) begin
          ctl.exec   = 1'b1;
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_RD_B;
        end
      end
      S_RD_B: begin
        ctl.cap_b = 1'b1;
        if (sts.need2) begin
          ctl.rd_second = 1'b1;
          state_next    = S_RD_A;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_RD_A: begin
        ctl.cap_a  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.long_op) begin
          ctl.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          ctl.exec = 1'b1;
          if (sts.is_swap) begin
            state_next = S_SWAP2;
          end else begin
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.is_roll) begin
            ctl.roll_setup = 1'b1;
            state_next     = S_RCOPY;
          end else begin
            ctl.exec   = 1'b1;
            ctl.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_SWAP2: begin
        ctl.swap2  = 1'b1;
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_RCOPY: begin
        ctl.roll_copy = 1'b1;
        if (sts.copy_last) state_next = S_RGAP;
      end
      S_RGAP: begin
        state_next = S_RWRITE;
      end
      S_RWRITE: begin
        ctl.roll_write = 1'b1;
        if (sts.write_last) state_next = S_RLAST;
      end
      S_RLAST: begin
        ctl.exec   = 1'b1;
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

@@ hw/rtl/stack_machine_execute_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core
// Executes one stack instruction per transfer on a 256-entry data stack.
// ----------------------------------------------------------------------------
// An instruction is taken when start is high and busy is low; its result
// appears on result with done high for exactly one cycle, and must be
// captured then. Nop, push, pop and operand faults finish straight from
// decode; other ops first read their operands through the single read
// port of the stack memory, div, mod and roll wait on the bit-serial
// divider, and roll then copies its entries out and writes them back.
// A new start is accepted in the cycle that done is shown.
module stack_machine_execute_unit_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  smx_pkg::instr_t  instr,
  output logic             busy,
  output logic             done,
  output smx_pkg::result_t result
);

  smx_pkg::ctrl_cmd_t  ctl;
  smx_pkg::dp_status_t sts;

  smx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  smx_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr),
    .ctl    (ctl),
    .sts    (sts),
    .result (result),
    .done   (done)
  );

endmodule

@@ hw/rtl/smx_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_checker
// Port-level checks for the stack machine execute unit.
// ----------------------------------------------------------------------------
module smx_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input smx_pkg::result_t result
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transfer did not raise busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.stack_count <= 9'd256)) else $error("stack count out of range");

  a_out_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !result.out_valid) |-> (result.out_value == 0 && !result.out_kind))
    else $error("output fields set without output");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.ignored && result.overflow)) else $error("ignored and overflow");

endmodule

bind stack_machine_execute_unit_core smx_checker u_smx_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
